>>> sv/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared constants for the vertex transform and projection unit.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegW     = 64;
  localparam int unsigned CompW    = 32;
  localparam int unsigned ProdW    = 2 * CompW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned IdxW     = 3;

  localparam logic signed [CompW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [CompW-1:0] QMin = 32'sh8000_0000;

endpackage

>>> sv/vtp_div_lane.sv
// ----------------------------------------------------------------------------
// vtp_div_lane
// Pipelined signed divider, one quotient bit per stage, saturating result.
// ----------------------------------------------------------------------------
module vtp_div_lane #(
  parameter int unsigned NUM_W = 48
) (
  input  logic                               clk_i,
  input  logic [NUM_W-1:0]                   num_mag_i,
  input  logic [vtp_pkg::CompW-1:0]          den_mag_i,
  input  logic                               neg_i,
  output logic signed [vtp_pkg::CompW-1:0]   quot_o,
  output logic                               sat_o
);

  localparam int unsigned DW = vtp_pkg::CompW;

  logic [NUM_W-1:0] num_q  [0:NUM_W];
  logic [NUM_W-1:0] quo_q  [0:NUM_W];
  logic [DW-1:0]    rem_q  [0:NUM_W];
  logic [DW-1:0]    den_q  [0:NUM_W];
  logic             neg_q  [0:NUM_W];

  always_ff @(posedge clk_i) begin
    num_q[0] <= num_mag_i;
    quo_q[0] <= '0;
    rem_q[0] <= '0;
    den_q[0] <= den_mag_i;
    neg_q[0] <= neg_i;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DW:0] trial;
    logic        fits;
    logic [DW:0] diff;
    assign trial = {rem_q[k], num_q[k][NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_q[k]});
    assign diff  = trial - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      num_q[k+1] <= {num_q[k][NUM_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][NUM_W-2:0], fits};
      rem_q[k+1] <= fits ? diff[DW-1:0] : trial[DW-1:0];
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] lim_pos;
  logic [NUM_W-1:0] lim_neg;
  logic signed [DW-1:0] quot_d;
  logic sat_d;

  assign mag     = quo_q[NUM_W];
  assign lim_pos = NUM_W'(32'h7fff_ffff);
  assign lim_neg = NUM_W'(33'h1_0000_0000 >> 1);

  always_comb begin
    sat_d  = 1'b0;
    quot_d = DW'(mag);
    if (!neg_q[NUM_W]) begin
      if (mag > lim_pos) begin
        sat_d  = 1'b1;
        quot_d = vtp_pkg::QMax;
      end
    end else begin
      if (mag > lim_neg) begin
        sat_d  = 1'b1;
        quot_d = vtp_pkg::QMin;
      end else begin
        quot_d = -DW'(mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_o <= quot_d;
    sat_o  <= sat_d;
  end

endmodule

>>> sv/vertex_transform_project_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_project_unit
// 4x4 matrix times vertex, then perspective divide of x, y and z by the transformed w unless w is zero.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle; busy_o is always low. Each result
// reaches out_valid_o through three multiply/sum/clamp stages, then a divider
// of one quotient bit per stage over 32 + FRAC_BITS stages plus its input and
// output registers, then the output register. The receiver cannot stall the
// block.
module vertex_transform_project_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vtp_pkg::AddrW-1:0]             paddr,
  input  logic [vtp_pkg::RegW-1:0]              pwdata,
  output logic [vtp_pkg::RegW-1:0]              prdata,
  output logic                                  pready,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [vtp_pkg::CompW-1:0]      in_x_i,
  input  logic signed [vtp_pkg::CompW-1:0]      in_y_i,
  input  logic signed [vtp_pkg::CompW-1:0]      in_z_i,
  input  logic signed [vtp_pkg::CompW-1:0]      in_w_i,
  output logic                                  out_valid_o,
  output logic signed [vtp_pkg::CompW-1:0]      out_x_o,
  output logic signed [vtp_pkg::CompW-1:0]      out_y_o,
  output logic signed [vtp_pkg::CompW-1:0]      out_z_o,
  output logic signed [vtp_pkg::CompW-1:0]      out_w_o,
  output logic                                  w_was_zero_o,
  output logic                                  saturated_o
);

  localparam int unsigned CW    = vtp_pkg::CompW;
  localparam int unsigned NUM_W = CW + FRAC_BITS;
  localparam int unsigned LAT   = NUM_W + 2;
  localparam logic [vtp_pkg::RegW-1:0] One = vtp_pkg::RegW'(1) << FRAC_BITS;

  // configuration registers
  logic [vtp_pkg::RegW-1:0] mat_q [0:vtp_pkg::NumRegs-1];
  logic [vtp_pkg::IdxW-1:0] widx;

  assign widx   = paddr[vtp_pkg::AddrW-1:vtp_pkg::AddrW-vtp_pkg::IdxW];
  assign pready = 1'b1;
  assign prdata = mat_q[widx];
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= One;
      mat_q[1] <= '0;
      mat_q[2] <= One << CW;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= One;
      mat_q[6] <= '0;
      mat_q[7] <= One << CW;
    end else if (psel && penable && pwrite && pready) begin
      mat_q[widx] <= pwdata;
    end
  end

  // stage 1: products
  logic signed [CW-1:0]            vec [0:3];
  logic signed [vtp_pkg::ProdW-1:0] prod_q [0:3][0:3];
  logic                             v1_q, v2_q, v3_q;

  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [CW-1:0] ent;
      assign ent = mat_q[2*r + c/2][CW*(c%2) +: CW];
      always_ff @(posedge clk_i) begin
        prod_q[r][c] <= vtp_pkg::ProdW'(ent) * vtp_pkg::ProdW'(vec[c]);
      end
    end
  end

  // stage 2: row sums
  logic signed [vtp_pkg::SumW-1:0] sum_q [0:3];
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      sum_q[r] <= vtp_pkg::SumW'(prod_q[r][0]) + vtp_pkg::SumW'(prod_q[r][1])
                + vtp_pkg::SumW'(prod_q[r][2]) + vtp_pkg::SumW'(prod_q[r][3]);
    end
  end

  // stage 3: floor shift and clamp
  logic signed [CW-1:0] res_q [0:3];
  logic                 rsat_q;
  logic signed [CW-1:0] res_d [0:3];
  logic                 rsat_d;

  always_comb begin
    logic signed [vtp_pkg::SumW-1:0] sh;
    rsat_d = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sh = sum_q[r] >>> FRAC_BITS;
      if (sh > vtp_pkg::SumW'(vtp_pkg::QMax)) begin
        res_d[r] = vtp_pkg::QMax;
        rsat_d   = 1'b1;
      end else if (sh < vtp_pkg::SumW'(vtp_pkg::QMin)) begin
        res_d[r] = vtp_pkg::QMin;
        rsat_d   = 1'b1;
      end else begin
        res_d[r] = sh[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    rsat_q <= rsat_d;
  end

  // divider lanes
  logic [CW-1:0]        den_mag;
  logic signed [CW-1:0] quot [0:2];
  logic                 qsat [0:2];

  assign den_mag = res_q[3][CW-1] ? -res_q[3] : res_q[3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [CW-1:0] nmag;
    assign nmag = res_q[l][CW-1] ? -res_q[l] : res_q[l];
    vtp_div_lane #(
      .NUM_W (NUM_W)
    ) u_div (
      .clk_i     (clk_i),
      .num_mag_i ({nmag, {FRAC_BITS{1'b0}}}),
      .den_mag_i (den_mag),
      .neg_i     (res_q[l][CW-1] ^ res_q[3][CW-1]),
      .quot_o    (quot[l]),
      .sat_o     (qsat[l])
    );
  end

  // side band that travels alongside the divider
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [CW-1:0] w;
    logic          sat;
  } side_t;

  side_t side_q [0:LAT-1];
  logic  sv_q   [0:LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) sv_q[i] <= 1'b0;
    end else begin
      sv_q[0] <= v3_q;
      for (int i = 1; i < LAT; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{x: res_q[0], y: res_q[1], z: res_q[2], w: res_q[3], sat: rsat_q};
    for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
  end

  // output register
  side_t tail;
  logic  wz;
  assign tail = side_q[LAT-1];
  assign wz   = (tail.w == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= sv_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_o      <= wz ? tail.x : quot[0];
    out_y_o      <= wz ? tail.y : quot[1];
    out_z_o      <= wz ? tail.z : quot[2];
    out_w_o      <= tail.w;
    w_was_zero_o <= wz;
    saturated_o  <= tail.sat | (!wz & (qsat[0] | qsat[1] | qsat[2]));
  end

endmodule

>>> test/vertex_transform_project_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_project_checker
// Watches the register port, the request channel and the result channel of
// the vertex transform unit. Keeps its own copy of the matrix, works out the
// projected vertex for every accepted request and compares each result, in
// order, field by field.
// ----------------------------------------------------------------------------
module vertex_transform_project_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vtp_pkg::AddrW-1:0]          paddr,
  input  logic [vtp_pkg::RegW-1:0]           pwdata,
  input  logic                               pready,
  input  logic                               start_i,
  input  logic                               busy_o,
  input  logic signed [vtp_pkg::CompW-1:0]   in_x_i,
  input  logic signed [vtp_pkg::CompW-1:0]   in_y_i,
  input  logic signed [vtp_pkg::CompW-1:0]   in_z_i,
  input  logic signed [vtp_pkg::CompW-1:0]   in_w_i,
  input  logic                               out_valid_o,
  input  logic signed [vtp_pkg::CompW-1:0]   out_x_o,
  input  logic signed [vtp_pkg::CompW-1:0]   out_y_o,
  input  logic signed [vtp_pkg::CompW-1:0]   out_z_o,
  input  logic signed [vtp_pkg::CompW-1:0]   out_w_o,
  input  logic                               w_was_zero_o,
  input  logic                               saturated_o,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  typedef struct packed {
    logic signed [vtp_pkg::CompW-1:0] x;
    logic signed [vtp_pkg::CompW-1:0] y;
    logic signed [vtp_pkg::CompW-1:0] z;
    logic signed [vtp_pkg::CompW-1:0] w;
    logic                             w_zero;
    logic                             sat;
  } vertex_t;

  logic [vtp_pkg::RegW-1:0] matrix_q [vtp_pkg::NumRegs];
  vertex_t                  projected_q [$];
  int                       fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = projected_q.size();

  function automatic logic signed [vtp_pkg::CompW-1:0] matrix_entry(int r, int c);
    logic [vtp_pkg::RegW-1:0] word;
    word = matrix_q[2*r + c/2];
    return (c % 2) ? word[63:32] : word[31:0];
  endfunction

  function automatic logic signed [vtp_pkg::CompW-1:0] clamp_q(logic signed [65:0] v,
                                                               ref logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return vtp_pkg::QMax;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return vtp_pkg::QMin;
    end
    return v[vtp_pkg::CompW-1:0];
  endfunction

  function automatic vertex_t project_vertex(logic signed [vtp_pkg::CompW-1:0] vx,
                                             logic signed [vtp_pkg::CompW-1:0] vy,
                                             logic signed [vtp_pkg::CompW-1:0] vz,
                                             logic signed [vtp_pkg::CompW-1:0] vw);
    logic signed [vtp_pkg::CompW-1:0] vec [4];
    logic signed [vtp_pkg::CompW-1:0] comp [4];
    logic signed [65:0] acc, a, b, num, den;
    logic sat;
    vertex_t res;
    vec[0] = vx; vec[1] = vy; vec[2] = vz; vec[3] = vw;
    sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        a = matrix_entry(r, c);
        b = vec[c];
        acc += a * b;
      end
      // arithmetic shift floors the exact sum
      comp[r] = clamp_q(acc >>> FRAC_BITS, sat);
    end
    res.w_zero = (comp[3] == 0);
    if (!res.w_zero) begin
      den = comp[3];
      for (int r = 0; r < 3; r++) begin
        num = comp[r];
        num = num <<< FRAC_BITS;
        comp[r] = clamp_q(num / den, sat);
      end
    end
    res.x = comp[0]; res.y = comp[1]; res.z = comp[2]; res.w = comp[3];
    res.sat = sat;
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= 64'h1 << FRAC_BITS;
      matrix_q[1] <= '0;
      matrix_q[2] <= (64'h1 << FRAC_BITS) << 32;
      matrix_q[3] <= '0;
      matrix_q[4] <= '0;
      matrix_q[5] <= 64'h1 << FRAC_BITS;
      matrix_q[6] <= '0;
      matrix_q[7] <= (64'h1 << FRAC_BITS) << 32;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr / 8 < vtp_pkg::NumRegs) matrix_q[paddr / 8] <= pwdata;
    end
  end

  initial fail_count = 0;

  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni) begin
      if (out_valid_o) begin
        got = '{out_x_o, out_y_o, out_z_o, out_w_o, w_was_zero_o, saturated_o};
        if (projected_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                   out_x_o, out_y_o, out_z_o, out_w_o);
          fail_count++;
        end else begin
          want = projected_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     $time, want.x, want.y, want.z, want.w, want.w_zero, want.sat);
            $display("%0t:                 actual   x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     $time, got.x, got.y, got.z, got.w, got.w_zero, got.sat);
            fail_count++;
          end
        end
      end
      // matrix_q still holds the value seen by this request
      if (start_i && !busy_o)
        projected_q.push_back(project_vertex(in_x_i, in_y_i, in_z_i, in_w_i));
    end
  end

endmodule

>>> test/vertex_transform_project_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_project_unit_tb
// Streams vertices through the transform unit under a series of matrices:
// identity, random, saturating extremes and all zero. Requests come with
// random gaps; a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module vertex_transform_project_unit_tb;

  localparam int unsigned FracBits  = 16;
  localparam int          Latency   = FracBits + 39;
  localparam int          ItemsEach = 135;

  typedef enum int {
    MatRandomSmall, MatRandomFull, MatAllMax, MatAllMin, MatZero, MatMixed
  } matrix_style_e;

  logic                              clk_i, rst_ni;
  logic                              psel, penable, pwrite, pready;
  logic [vtp_pkg::AddrW-1:0]         paddr;
  logic [vtp_pkg::RegW-1:0]          pwdata, prdata;
  logic                              start_i, busy_o;
  logic signed [vtp_pkg::CompW-1:0]  in_x_i, in_y_i, in_z_i, in_w_i;
  logic                              out_valid_o;
  logic signed [vtp_pkg::CompW-1:0]  out_x_o, out_y_o, out_z_o, out_w_o;
  logic                              w_was_zero_o, saturated_o;
  int                                fail_count, pending;

  vertex_transform_project_unit #(.FRAC_BITS(FracBits)) u_dut (.*);

  vertex_transform_project_checker #(.FRAC_BITS(FracBits)) u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  task automatic reg_write(int idx, logic [vtp_pkg::RegW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = vtp_pkg::AddrW'(idx * 8); pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(negedge clk_i); while (!pready);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic idle_gap();
    int n, pick;
    pick = $urandom_range(0, 99);
    n = (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance and an idle gap
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w);
    start_i = 1'b1;
    in_x_i = x; in_y_i = y; in_z_i = z; in_w_i = w;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
    idle_gap();
  endtask

  function automatic logic [31:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom();
    if (pick == 3) return 32'($urandom_range(0, 3)) - 32'sd1;
    return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
  endfunction

  function automatic logic [31:0] matrix_value(matrix_style_e style);
    case (style)
      MatAllMax:     return 32'h7fff_ffff;
      MatAllMin:     return 32'h8000_0000;
      MatZero:       return 32'h0;
      MatRandomFull: return $urandom();
      MatMixed: begin
        return ($urandom_range(0, 3) == 0) ? $urandom() :
               32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      end
      default:       return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    endcase
  endfunction

  task automatic load_matrix(matrix_style_e style);
    // no request can be in flight while the matrix changes
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    for (int i = 0; i < vtp_pkg::NumRegs; i++)
      reg_write(i, {matrix_value(style), matrix_value(style)});
  endtask

  initial begin
    matrix_style_e order [7];
    rst_ni = 1'b0; start_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_x_i = '0; in_y_i = '0; in_z_i = '0; in_w_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // identity matrix: plain, zero w, min/max fields, quotient overflow
    send_vertex(32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0000_8000, 32'hfffe_0000);
    send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h0000_0100);

    // extremes of the matrix: sums clamp, all-zero rows give zero w
    load_matrix(MatAllMax);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0);
    load_matrix(MatAllMin);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_matrix(MatZero);
    send_vertex(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);

    order = '{MatRandomSmall, MatMixed, MatRandomFull, MatAllMax,
              MatRandomSmall, MatAllMin, MatMixed};
    foreach (order[p]) begin
      load_matrix(order[p]);
      repeat (ItemsEach - (order[p] inside {MatAllMax, MatAllMin} ? 100 : 0))
        send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end

    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
